>>> rtl/upq_pkg.sv
package upq_pkg;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [KIND_W-1:0] K_ENQ  = 3'd0;
    localparam logic [KIND_W-1:0] K_DEQ  = 3'd1;
    localparam logic [KIND_W-1:0] K_PEEK = 3'd2;
    localparam logic [KIND_W-1:0] K_CHG  = 3'd3;
    localparam logic [KIND_W-1:0] K_CLR  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_NOT_URGENT = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_FIND,
        S_CHG,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    wr_tail;
        logic    clr_cnt;
        logic    dec_cnt;
        logic    scan_start;
        logic    shift_start;
        logic    run;
        logic    best_upd;
        logic    grab;
        logic    wr_shift;
        logic    wr_chg;
        logic    res_none;
        logic    res_best;
        t_status res_st;
        logic    push;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              rd_vld;
        logic              rd_last;
        logic              match;
        logic              best_last;
        logic              keep;
    } t_stat;

endpackage

>>> rtl/upq_ram.sv
module upq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/upq_ctrl.sv
module upq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  upq_pkg::t_stat i_stat,
    output upq_pkg::t_cmd  o_cmd
);
    import upq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.kind) inside
                    K_ENQ: begin
                        cmd.res_none = 1'b1;
                        if (i_stat.full) begin
                            cmd.res_st = ST_FULL;
                        end else begin
                            cmd.wr_tail = 1'b1;
                        end
                        n_state = S_OUT;
                    end
                    K_DEQ, K_PEEK: begin
                        if (i_stat.empty) begin
                            cmd.res_none = 1'b1;
                            cmd.res_st   = ST_EMPTY;
                            n_state      = S_OUT;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    K_CHG: begin
                        if (i_stat.empty) begin
                            cmd.res_none = 1'b1;
                            cmd.res_st   = ST_NOT_FOUND;
                            n_state      = S_OUT;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_FIND;
                        end
                    end
                    K_CLR: begin
                        cmd.clr_cnt  = 1'b1;
                        cmd.res_none = 1'b1;
                        n_state      = S_OUT;
                    end
                    default: begin
                        cmd.res_none = 1'b1;
                        n_state      = S_OUT;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.run      = 1'b1;
                cmd.best_upd = 1'b1;
                if (i_stat.rd_vld && i_stat.rd_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                cmd.res_best = 1'b1;
                n_state      = S_OUT;
                if (i_stat.kind == K_DEQ) begin
                    if (i_stat.best_last) begin
                        cmd.dec_cnt = 1'b1;
                    end else begin
                        cmd.shift_start = 1'b1;
                        n_state         = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                cmd.run      = 1'b1;
                cmd.wr_shift = 1'b1;
                if (i_stat.rd_vld && i_stat.rd_last) begin
                    cmd.dec_cnt = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_FIND: begin
                cmd.run = 1'b1;
                if (i_stat.rd_vld && i_stat.match) begin
                    cmd.grab = 1'b1;
                    n_state  = S_CHG;
                end else if (i_stat.rd_vld && i_stat.rd_last) begin
                    cmd.res_none = 1'b1;
                    cmd.res_st   = ST_NOT_FOUND;
                    n_state      = S_OUT;
                end
            end
            S_CHG: begin
                cmd.res_none = 1'b1;
                if (i_stat.keep) begin
                    cmd.wr_chg = 1'b1;
                end else begin
                    cmd.res_st = ST_NOT_URGENT;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || !i_stall) begin
                    cmd.push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
        if (cmd.push) begin
            n_out_vld = 1'b1;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

endmodule

>>> rtl/upq_dp.sv
module upq_dp #(
    parameter int CAPACITY      = 16,
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [upq_pkg::KIND_W-1:0]        i_kind,
    input  logic [VALUE_BITS-1:0]             i_value,
    input  logic signed [PRIORITY_BITS-1:0]   i_priority_req,
    input  upq_pkg::t_cmd                     i_cmd,
    output upq_pkg::t_stat                    o_stat,
    output logic [VALUE_BITS-1:0]             o_out_value,
    output logic signed [PRIORITY_BITS-1:0]   o_out_priority,
    output logic [upq_pkg::STATUS_W-1:0]      o_status,
    output logic [upq_pkg::COUNT_W-1:0]       o_count
);
    import upq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ENT_W  = VALUE_BITS + PRIORITY_BITS;

    // control
    logic [CNT_W-1:0]  r_count;
    logic              r_iss;
    logic              r_rd_vld;

    // payload
    logic [KIND_W-1:0]               r_kind;
    logic [VALUE_BITS-1:0]           r_value;
    logic signed [PRIORITY_BITS-1:0] r_pri;
    logic [ADDR_W-1:0]               r_addr;
    logic [ADDR_W-1:0]               r_rd_idx;
    logic [ADDR_W-1:0]               r_best_idx;
    logic [VALUE_BITS-1:0]           r_best_val;
    logic signed [PRIORITY_BITS-1:0] r_best_pri;
    logic                            r_best_vld;
    logic [VALUE_BITS-1:0]           r_res_val;
    logic signed [PRIORITY_BITS-1:0] r_res_pri;
    t_status                         r_res_st;
    logic [VALUE_BITS-1:0]           r_out_val;
    logic signed [PRIORITY_BITS-1:0] r_out_pri;
    t_status                         r_out_st;
    logic [COUNT_W-1:0]              r_out_cnt;

    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [ENT_W-1:0]                ram_wdata;
    logic [ENT_W-1:0]                ram_rdata;
    logic [VALUE_BITS-1:0]           rd_val;
    logic signed [PRIORITY_BITS-1:0] rd_pri;
    logic [CNT_W-1:0]                cnt_m1;
    logic                            rd_better;
    logic                            iss_last;

    upq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_val    = ram_rdata[ENT_W-1 -: VALUE_BITS];
    assign rd_pri    = $signed(ram_rdata[PRIORITY_BITS-1:0]);
    assign cnt_m1    = r_count - 1'b1;
    assign iss_last  = (CNT_W'(r_addr) == cnt_m1);
    assign rd_better = !r_best_vld || (rd_pri < r_best_pri)
                       || ((rd_pri == r_best_pri) && (rd_val < r_best_val));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        ram_wdata = {r_best_val, r_pri};
        if (i_cmd.wr_tail) begin
            ram_we    = 1'b1;
            ram_waddr = r_count[ADDR_W-1:0];
            ram_wdata = {r_value, r_pri};
        end else if (i_cmd.wr_shift) begin
            ram_we    = r_rd_vld;
            ram_waddr = r_rd_idx - 1'b1;
            ram_wdata = ram_rdata;
        end else if (i_cmd.wr_chg) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_iss    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clr_cnt) begin
                r_count <= '0;
            end else if (i_cmd.wr_tail) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.dec_cnt) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.scan_start || i_cmd.shift_start) begin
                r_iss    <= 1'b1;
                r_rd_vld <= 1'b0;
            end else begin
                r_rd_vld <= i_cmd.run && r_iss;
                if (i_cmd.run && r_iss && iss_last) begin
                    r_iss <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_pri   <= i_priority_req;
        end
        if (i_cmd.scan_start) begin
            r_addr     <= '0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.shift_start) begin
            r_addr <= r_best_idx + 1'b1;
        end else if (i_cmd.run && r_iss) begin
            r_rd_idx <= r_addr;
            if (!iss_last) begin
                r_addr <= r_addr + 1'b1;
            end
        end
        if ((i_cmd.best_upd && r_rd_vld && rd_better) || i_cmd.grab) begin
            r_best_idx <= r_rd_idx;
            r_best_val <= rd_val;
            r_best_pri <= rd_pri;
            r_best_vld <= 1'b1;
        end
        if (i_cmd.res_none) begin
            r_res_val <= '0;
            r_res_pri <= '0;
            r_res_st  <= i_cmd.res_st;
        end else if (i_cmd.res_best) begin
            r_res_val <= r_best_val;
            r_res_pri <= r_best_pri;
            r_res_st  <= ST_OK;
        end
        if (i_cmd.push) begin
            r_out_val <= r_res_val;
            r_out_pri <= r_res_pri;
            r_out_st  <= r_res_st;
            r_out_cnt <= COUNT_W'(r_count);
        end
    end

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count >= CNT_W'(CAPACITY));
        o_stat.rd_vld    = r_rd_vld;
        o_stat.rd_last   = (CNT_W'(r_rd_idx) == cnt_m1);
        o_stat.match     = (rd_val == r_value);
        o_stat.best_last = (CNT_W'(r_best_idx) == cnt_m1);
        o_stat.keep      = (r_best_pri >= r_pri);
    end

    assign o_out_value    = r_out_val;
    assign o_out_priority = r_out_pri;
    assign o_status       = r_out_st;
    assign o_count        = r_out_cnt;

endmodule

>>> rtl/unsorted_array_priority_queue_top.sv
// channel   direction  beat accepted when     payload
// input     in         i_valid && !o_stall    i_kind, i_value, i_priority_req
// result    out        o_valid && !i_stall    o_out_value, o_out_priority, o_status, o_count
//
// one beat in flight at a time; o_stall is high from acceptance until the result is registered
// enqueue, clear, unused kinds and empty cases: decode, then straight to the result register
// peek scans all entries; dequeue also shifts later entries down, through the single read port
// change priority: scans only up to the first matching entry
// i_rst_n is synchronous active low and empties the queue; entry memory is not cleared
// a new beat is taken while the previous result still waits under i_stall
module unsorted_array_priority_queue_top #(
    parameter int CAPACITY      = 16,
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request side
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [upq_pkg::KIND_W-1:0]        i_kind,
    input  logic [VALUE_BITS-1:0]             i_value,
    input  logic signed [PRIORITY_BITS-1:0]   i_priority_req,
    // result side
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [VALUE_BITS-1:0]             o_out_value,
    output logic signed [PRIORITY_BITS-1:0]   o_out_priority,
    output logic [upq_pkg::STATUS_W-1:0]      o_status,
    output logic [upq_pkg::COUNT_W-1:0]       o_count
);
    import upq_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: decodes the operation, runs the scan and shift passes,
    // and owns the result valid flag
    upq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: entry memory, fill count, scan address, best-entry tracker
    // and the result register
    upq_dp #(
        .CAPACITY      (CAPACITY),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_count        (o_count)
    );

endmodule

>>> rtl/upq_checker.sv
module upq_props #(
    parameter int CAPACITY      = 16,
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [VALUE_BITS-1:0]             o_out_value,
    input logic signed [PRIORITY_BITS-1:0]   o_out_priority,
    input logic [upq_pkg::STATUS_W-1:0]      o_status,
    input logic [upq_pkg::COUNT_W-1:0]       o_count
);
    import upq_pkg::*;

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped under stall");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_value) && $stable(o_out_priority)
            && $stable(o_status) && $stable(o_count))
        else $error("result payload changed under stall");

    // empty status only with nothing held
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with non-zero count");

    // full status only at capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // failed operations carry no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_out_value == '0) && (o_out_priority == '0))
        else $error("failed result carries entry data");

endmodule

bind unsorted_array_priority_queue_top upq_props #(
    .CAPACITY      (CAPACITY),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
) u_upq_props (.*);

>>> dv/upq_checker.sv
`timescale 1ns / 1ps

module upq_checker #(
    parameter int CAPACITY      = 16,
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_req_valid,
    input  logic                              i_req_stall,
    input  logic [upq_pkg::KIND_W-1:0]        i_kind,
    input  logic [VALUE_BITS-1:0]             i_value,
    input  logic signed [PRIORITY_BITS-1:0]   i_priority_req,
    // result channel
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic [VALUE_BITS-1:0]             i_out_value,
    input  logic signed [PRIORITY_BITS-1:0]   i_out_priority,
    input  logic [upq_pkg::STATUS_W-1:0]      i_status,
    input  logic [upq_pkg::COUNT_W-1:0]       i_count,
    // totals for the verdict
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_results,
    output int                                o_error_results
);
    import upq_pkg::*;

    typedef struct packed {
        logic [VALUE_BITS-1:0]           value;
        logic signed [PRIORITY_BITS-1:0] prio;
        t_status                         status;
        logic [COUNT_W-1:0]              count;
    } t_outcome;

    // shadow of the queue, in arrival order
    logic [VALUE_BITS-1:0]           held_val [$];
    logic signed [PRIORITY_BITS-1:0] held_pri [$];

    t_outcome outcome_q [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic t_outcome queue_apply(input logic [KIND_W-1:0] kind,
                                             input logic [VALUE_BITS-1:0] val,
                                             input logic signed [PRIORITY_BITS-1:0] pri);
        t_outcome res;
        int       best;
        bit       hit;
        res        = '0;
        res.status = ST_OK;
        case (kind) inside
            K_ENQ: begin
                if (held_val.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    held_val.push_back(val);
                    held_pri.push_back(pri);
                end
            end
            K_DEQ, K_PEEK: begin
                if (held_val.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // lowest priority, then smallest value, then earliest
                    best = 0;
                    for (int i = 1; i < held_val.size(); i++) begin
                        if (held_pri[i] < held_pri[best] ||
                            (held_pri[i] == held_pri[best] && held_val[i] < held_val[best]))
                            best = i;
                    end
                    res.value = held_val[best];
                    res.prio  = held_pri[best];
                    if (kind == K_DEQ) begin
                        held_val.delete(best);
                        held_pri.delete(best);
                    end
                end
            end
            K_CHG: begin
                // only the first match in arrival order is looked at
                res.status = ST_NOT_FOUND;
                hit        = 1'b0;
                for (int i = 0; i < held_val.size(); i++) begin
                    if (!hit && held_val[i] == val) begin
                        hit = 1'b1;
                        if (held_pri[i] >= pri) begin
                            held_pri[i] = pri;
                            res.status  = ST_OK;
                        end else begin
                            res.status = ST_NOT_URGENT;
                        end
                    end
                end
            end
            K_CLR: begin
                held_val.delete();
                held_pri.delete();
            end
            default: ;
        endcase
        res.count = COUNT_W'(held_val.size());
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            held_val.delete();
            held_pri.delete();
            outcome_q.delete();
            o_fail_count    = 0;
            o_results       = 0;
            o_error_results = 0;
        end else begin
            if (i_req_valid && !i_req_stall)
                outcome_q.push_back(queue_apply(i_kind, i_value, i_priority_req));
            if (i_res_valid && !i_res_stall) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result beat with no request outstanding, status",
                                    int'(i_status), 0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_out_value !== want.value)
                        report_mismatch("out_value", int'(i_out_value), int'(want.value));
                    if (i_out_priority !== want.prio)
                        report_mismatch("out_priority", int'(i_out_priority),
                                        int'(want.prio));
                    if (i_status !== want.status)
                        report_mismatch("status", int'(i_status), int'(want.status));
                    if (i_count !== want.count)
                        report_mismatch("count", int'(i_count), int'(want.count));
                    o_results++;
                    if (want.status != ST_OK)
                        o_error_results++;
                end
            end
        end
        o_pending <= outcome_q.size();
    end

endmodule

>>> dv/tb_unsorted_array_priority_queue_top.sv
`timescale 1ns / 1ps

module tb_unsorted_array_priority_queue_top;
    import upq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int VALUE_BITS    = 16;
    localparam int PRIORITY_BITS = 16;

    // cycles without any beat before the run is declared hung; a dequeue of a full
    // queue scans and then shifts the later entries, and result stalls lengthen it
    localparam int IDLE_LIMIT   = 2000;
    // settling time after the last result, longer than the slowest dequeue
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int RANDOM_BEATS = 1200;
    localparam int SEGMENT      = 40;

    // kinds with no operation behind them
    localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;

    // random phases, chosen per segment
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    localparam logic signed [PRIORITY_BITS-1:0] PRI_MIN = {1'b1, {(PRIORITY_BITS-1){1'b0}}};
    localparam logic signed [PRIORITY_BITS-1:0] PRI_MAX = {1'b0, {(PRIORITY_BITS-1){1'b1}}};

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic [KIND_W-1:0]               i_kind  = '0;
    logic [VALUE_BITS-1:0]           i_value = '0;
    logic signed [PRIORITY_BITS-1:0] i_priority_req = '0;
    logic                            i_stall = 1'b0;
    logic                            o_stall;
    logic                            o_valid;
    logic [VALUE_BITS-1:0]           o_out_value;
    logic signed [PRIORITY_BITS-1:0] o_out_priority;
    logic [STATUS_W-1:0]             o_status;
    logic [COUNT_W-1:0]              o_count;

    // no_gaps switches both sides to full rate for a stretch of the run
    logic no_gaps = 1'b0;
    int   beats_sent = 0;
    int   directed_beats;

    int fail_count;
    int pending;
    int results;
    int error_results;

    always #5 i_clk = ~i_clk;

    unsorted_array_priority_queue_top #(
        .CAPACITY      (CAPACITY),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_count        (o_count)
    );

    upq_checker #(
        .CAPACITY      (CAPACITY),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_priority_req  (i_priority_req),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_out_value     (o_out_value),
        .i_out_priority  (o_out_priority),
        .i_status        (o_status),
        .i_count         (o_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results),
        .o_error_results (error_results)
    );

    // result side back-pressure, about 29 percent of the time outside the full-rate stretch
    always @(posedge i_clk) begin
        i_stall <= !no_gaps && ($urandom_range(0, 99) < 29);
    end

    // one request beat: optional idle cycles, then hold the payload until taken
    task automatic send_beat(input logic [KIND_W-1:0] kind,
                             input logic [VALUE_BITS-1:0] val,
                             input logic signed [PRIORITY_BITS-1:0] pri);
        while (!no_gaps && $urandom_range(0, 99) < 29) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_value        <= val;
        i_priority_req <= pri;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        beats_sent++;
    endtask

    // random beat; the mix of kinds depends on the phase so the queue swings
    // between empty and full and change priority mostly finds its value
    task automatic random_beat(input int mode);
        int                              pick;
        int                              enq_cut;
        int                              deq_cut;
        logic [KIND_W-1:0]               kind;
        logic [VALUE_BITS-1:0]           val;
        logic signed [PRIORITY_BITS-1:0] pri;
        case (mode)
            MODE_FILL: begin
                enq_cut = 70;
                deq_cut = 80;
            end
            MODE_DRAIN: begin
                enq_cut = 25;
                deq_cut = 70;
            end
            default: begin
                enq_cut = 45;
                deq_cut = 65;
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < enq_cut)
            kind = K_ENQ;
        else if (pick < deq_cut)
            kind = K_DEQ;
        else if (pick < deq_cut + 10)
            kind = K_PEEK;
        else if (pick < deq_cut + 25)
            kind = K_CHG;
        else if (pick < deq_cut + 28)
            kind = K_CLR;
        else
            kind = KIND_W'($urandom_range(int'(K_SPARE_FIRST), int'(K_SPARE_LAST)));

        // small tag pool for duplicates and change hits, now and then any tag
        pick = $urandom_range(0, 99);
        if (pick < 75)
            val = VALUE_BITS'($urandom_range(0, 15));
        else if (pick < 80)
            val = '1;
        else
            val = VALUE_BITS'($urandom);

        // narrow band gives priority ties, the rest spans the whole range
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            pri = PRIORITY_BITS'($urandom_range(0, 8) - 4);
        end else if (pick < 80) begin
            pri = PRIORITY_BITS'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0:       pri = PRI_MIN;
                1:       pri = PRI_MAX;
                2:       pri = PRI_MIN + PRIORITY_BITS'(1);
                default: pri = PRI_MAX - PRIORITY_BITS'(1);
            endcase
        end
        send_beat(kind, val, pri);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: empty queue cases first
        send_beat(K_PEEK, 16'hFFFF, PRI_MAX);
        send_beat(K_DEQ, 16'h0000, PRI_MIN);
        send_beat(K_CHG, 16'h0000, PRI_MIN);          // nothing to find
        // clear when already empty
        send_beat(K_CLR, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));
        for (int k = int'(K_SPARE_FIRST); k <= int'(K_SPARE_LAST); k++)
            send_beat(KIND_W'(k), VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));

        // extremes of both fields, a priority tie and a full tie
        send_beat(K_ENQ, 16'hFFFF, PRI_MAX);
        send_beat(K_ENQ, 16'h0000, PRI_MIN);
        send_beat(K_ENQ, 16'h0001, PRI_MIN);
        send_beat(K_ENQ, 16'h0000, PRI_MIN);
        send_beat(K_PEEK, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));

        // change priority: equal request, less urgent request, duplicate, absent value
        send_beat(K_CHG, 16'hFFFF, PRI_MAX);
        send_beat(K_CHG, 16'h0001, 16'sd0);
        send_beat(K_CHG, 16'h0000, PRI_MIN);
        send_beat(K_CHG, 16'h5A5A, 16'sh1234);
        send_beat(K_DEQ, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));
        send_beat(K_DEQ, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));
        send_beat(K_CHG, 16'hFFFF, PRI_MIN);
        send_beat(K_DEQ, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));
        send_beat(K_CLR, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));
        send_beat(K_DEQ, VALUE_BITS'($urandom), PRIORITY_BITS'($urandom));
        directed_beats = beats_sent;

        // random part: fill, drain and mixed phases in turn, middle stretch at full rate
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 500)
                no_gaps <= 1'b1;
            if (n == 700)
                no_gaps <= 1'b0;
            random_beat((n / SEGMENT) % (MODE_MIXED + 1));
        end
        i_valid <= 1'b0;

        // wait for every outstanding result, then let the block settle
        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("covered %0d request beats: %0d directed, %0d random in fill/drain/mix phases",
                 beats_sent, directed_beats, beats_sent - directed_beats);
        $display("checked %0d results, %0d of them empty, full, not found or not more urgent",
                 results, error_results);
        if (fail_count == 0 && pending == 0) begin
            $display("unsorted_array_priority_queue_top test passed");
        end else begin
            $display("unsorted_array_priority_queue_top test failed");
        end
        $finish;
    end

    // watchdog: ends the run when neither channel has moved a beat for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat on either channel for %0d cycles", IDLE_LIMIT);
        $display("unsorted_array_priority_queue_top test failed");
        $finish;
    end

endmodule
